[hdl/epm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epm_pkg: shared types, constants and tables for euler_pose_to_matrix
// Commands, sequencer states, multiply micro-ops, CORDIC angle table and
// fixed-point helpers.
// ----------------------------------------------------------------------------
package epm_pkg;

	localparam int ANGLE_BITS_DEF      = 16;
	localparam int SINE_ITERATIONS_DEF = 16;
	localparam int ATAN_DEPTH          = 24;

	// Q2.30 CORDIC start vector (1/gain)
	localparam logic signed [31:0] CORDIC_START = 32'sh26DD3B6A;
	localparam logic signed [31:0] FIXED_ZERO   = 32'sd0;
	localparam logic signed [31:0] FIXED_ONE    = 32'sd65536;

	typedef enum logic [1:0] {
		CMD_SET_POS = 2'd0,
		CMD_ADD_POS = 2'd1,
		CMD_SET_ANG = 2'd2,
		CMD_ADD_ANG = 2'd3
	} cmd_t;

	// axis order of the stored pose
	localparam logic [1:0] AX_YAW   = 2'd0;
	localparam logic [1:0] AX_PITCH = 2'd1;
	localparam logic [1:0] AX_ROLL  = 2'd2;
	localparam logic [1:0] ROW_LAST = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TRIG_START,
		ST_TRIG_WAIT,
		ST_MUL,
		ST_MUL_DRAIN,
		ST_OUT
	} state_t;

	typedef enum logic [2:0] {
		SRC_SY, SRC_CY, SRC_SP, SRC_CP, SRC_SR, SRC_CR, SRC_CPSY, SRC_SPSY
	} src_t;

	typedef enum logic [3:0] {
		DST_CPSY, DST_SPSY, DST_M00, DST_M01, DST_M10,
		DST_M11, DST_M12, DST_M20, DST_M21, DST_M22
	} dst_t;

	localparam int ACC_DEPTH = 10;

	typedef enum logic [1:0] {
		ACC_SET, ACC_ADD, ACC_SUB
	} acc_mode_t;

	typedef struct packed {
		src_t      src_a;
		src_t      src_b;
		dst_t      dst;
		acc_mode_t mode;
	} mul_op_t;

	typedef struct packed {
		logic               done;
		logic signed [31:0] sin_v;
		logic signed [31:0] cos_v;
	} trig_res_t;

	localparam int         MUL_STEPS = 14;
	localparam logic [3:0] MUL_LAST  = 4'(MUL_STEPS - 1);

	// multiply program; cross products come first so later steps can use them
	function automatic mul_op_t mul_step(input logic [3:0] k);
		mul_op_t op;
		op = '{SRC_SY, SRC_SY, DST_CPSY, ACC_SET};
		case (k)
			4'd0:    op = '{SRC_CP,   SRC_SY, DST_CPSY, ACC_SET};
			4'd1:    op = '{SRC_SP,   SRC_SY, DST_SPSY, ACC_SET};
			4'd2:    op = '{SRC_CP,   SRC_CY, DST_M00,  ACC_SET};
			4'd3:    op = '{SRC_SP,   SRC_CY, DST_M01,  ACC_SET};
			4'd4:    op = '{SRC_CY,   SRC_SR, DST_M12,  ACC_SET};
			4'd5:    op = '{SRC_CY,   SRC_CR, DST_M22,  ACC_SET};
			4'd6:    op = '{SRC_CPSY, SRC_SR, DST_M10,  ACC_SET};
			4'd7:    op = '{SRC_SP,   SRC_CR, DST_M10,  ACC_SUB};
			4'd8:    op = '{SRC_SPSY, SRC_SR, DST_M11,  ACC_SET};
			4'd9:    op = '{SRC_CP,   SRC_CR, DST_M11,  ACC_ADD};
			4'd10:   op = '{SRC_CPSY, SRC_CR, DST_M20,  ACC_SET};
			4'd11:   op = '{SRC_SP,   SRC_SR, DST_M20,  ACC_ADD};
			4'd12:   op = '{SRC_SPSY, SRC_CR, DST_M21,  ACC_SET};
			4'd13:   op = '{SRC_CP,   SRC_SR, DST_M21,  ACC_SUB};
			default: op = '{SRC_SY,   SRC_SY, DST_CPSY, ACC_SET};
		endcase
		return op;
	endfunction

	// arctan(2^-i) in 2^-32 turn units
	function automatic logic [31:0] atan_turn(input logic [4:0] i);
		logic [31:0] v;
		v = 32'h0;
		case (i)
			5'd0:    v = 32'h20000000;
			5'd1:    v = 32'h12E4051E;
			5'd2:    v = 32'h09FB385B;
			5'd3:    v = 32'h051111D4;
			5'd4:    v = 32'h028B0D43;
			5'd5:    v = 32'h0145D7E1;
			5'd6:    v = 32'h00A2F61E;
			5'd7:    v = 32'h00517C55;
			5'd8:    v = 32'h0028BE53;
			5'd9:    v = 32'h00145F2F;
			5'd10:   v = 32'h000A2F98;
			5'd11:   v = 32'h000517CC;
			5'd12:   v = 32'h00028BE6;
			5'd13:   v = 32'h000145F3;
			5'd14:   v = 32'h0000A2FA;
			5'd15:   v = 32'h0000517D;
			5'd16:   v = 32'h000028BE;
			5'd17:   v = 32'h0000145F;
			5'd18:   v = 32'h00000A30;
			5'd19:   v = 32'h00000518;
			5'd20:   v = 32'h0000028C;
			5'd21:   v = 32'h00000146;
			5'd22:   v = 32'h000000A3;
			5'd23:   v = 32'h00000051;
			default: v = 32'h0;
		endcase
		return v;
	endfunction

	// signed add clamped to the 32-bit range
	function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
	                                               input logic signed [31:0] b);
		logic signed [32:0] s;
		s = {a[31], a} + {b[31], b};
		if (s[32] != s[31])
			return s[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
		return s[31:0];
	endfunction

	// Q2.30 (33-bit) to Q16.16, round half up
	function automatic logic [31:0] to_q16(input logic signed [32:0] v);
		logic signed [33:0] t;
		t = {v[32], v} + 34'sd8192;
		return {{12{t[33]}}, t[33:14]};
	endfunction

endpackage

[hdl/euler_pose_to_matrix.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euler_pose_to_matrix: camera pose keeper with a fixed-point pose matrix
// Applies set/add commands to position and yaw/pitch/roll, then streams the
// 4x4 pose matrix out as four rows.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata (low bit up)                         | tuser     | tlast
//  s_axis   | in  | pos_x, pos_y, pos_z, yaw, pitch, roll (144) | command   | -
//  m_axis   | out | entry_a, entry_b, entry_c, entry_d (128)    | row_index | last_row
//
//  Each command runs the single CORDIC unit (one rotation per cycle) once per
//  axis, then issues each product of the multiply program to the shared multiplier.
//  Rows leave one per cycle while m_axis_tready is high; the output register
//  holds a row under stall. s_axis_tready is high only between commands.
//  Reset clears the pose to zero (identity rotation, origin).
// ----------------------------------------------------------------------------
module euler_pose_to_matrix #(
	parameter int ANGLE_BITS      = epm_pkg::ANGLE_BITS_DEF,
	parameter int SINE_ITERATIONS = epm_pkg::SINE_ITERATIONS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [143:0] s_axis_tdata,   // pos_x, pos_y, pos_z, yaw, pitch, roll
	input  logic [1:0]   s_axis_tuser,   // command
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [127:0] m_axis_tdata,   // entry_a, entry_b, entry_c, entry_d
	output logic [1:0]   m_axis_tuser,   // row_index
	output logic         m_axis_tlast    // last_row
);

	// ---------------- input unpack ----------------
	epm_pkg::cmd_t      cmd;
	logic signed [31:0] in_pos [3];
	logic [15:0]        in_ang [3];

	assign cmd       = epm_pkg::cmd_t'(s_axis_tuser);
	assign in_pos[0] = s_axis_tdata[31:0];
	assign in_pos[1] = s_axis_tdata[63:32];
	assign in_pos[2] = s_axis_tdata[95:64];
	assign in_ang[0] = s_axis_tdata[111:96];
	assign in_ang[1] = s_axis_tdata[127:112];
	assign in_ang[2] = s_axis_tdata[143:128];

	// ---------------- state ----------------
	epm_pkg::state_t    state_q, state_nxt;
	logic [1:0]         ax_q;      // axis being evaluated
	logic [3:0]         step_q;    // multiply program counter
	logic [1:0]         row_q;     // next row to emit

	logic signed [31:0] pos_q [3];
	logic [15:0]        ang_q [3];
	logic signed [31:0] sin_q [3];
	logic signed [31:0] cos_q [3];
	logic signed [32:0] acc_q [epm_pkg::ACC_DEPTH];

	logic               pend_vld_s1;
	epm_pkg::mul_op_t   pend_op_s1;

	logic               out_vld_q;
	logic [127:0]       out_data_q;
	logic [1:0]         out_row_q;
	logic               out_last_q;

	// control strobes
	logic               in_xfer, trig_start, trig_wr, mul_issue, out_load, out_free;

	epm_pkg::trig_res_t trig;
	epm_pkg::mul_op_t   cur_op;
	logic signed [31:0] mul_a, mul_b, mul_q;
	logic signed [32:0] wb_val, acc_old;

	assign in_xfer  = s_axis_tvalid && s_axis_tready;
	assign out_free = !out_vld_q || m_axis_tready;

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= epm_pkg::ST_IDLE;
		else
			state_q <= state_nxt;
	end

	always_comb begin
		state_nxt     = state_q;
		s_axis_tready = 1'b0;
		trig_start    = 1'b0;
		trig_wr       = 1'b0;
		mul_issue     = 1'b0;
		out_load      = 1'b0;
		case (state_q)
			epm_pkg::ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid)
					state_nxt = epm_pkg::ST_TRIG_START;
			end
			epm_pkg::ST_TRIG_START: begin
				trig_start = 1'b1;
				state_nxt  = epm_pkg::ST_TRIG_WAIT;
			end
			epm_pkg::ST_TRIG_WAIT: begin
				if (trig.done) begin
					trig_wr   = 1'b1;
					state_nxt = (ax_q == epm_pkg::AX_ROLL) ? epm_pkg::ST_MUL :
					                                         epm_pkg::ST_TRIG_START;
				end
			end
			epm_pkg::ST_MUL: begin
				mul_issue = 1'b1;
				if (step_q == epm_pkg::MUL_LAST)
					state_nxt = epm_pkg::ST_MUL_DRAIN;
			end
			epm_pkg::ST_MUL_DRAIN: begin
				// last product is written back this cycle
				state_nxt = epm_pkg::ST_OUT;
			end
			epm_pkg::ST_OUT: begin
				if (out_free) begin
					out_load = 1'b1;
					if (row_q == epm_pkg::ROW_LAST)
						state_nxt = epm_pkg::ST_IDLE;
				end
			end
			default: state_nxt = epm_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ax_q        <= '0;
			step_q      <= '0;
			row_q       <= '0;
			pend_vld_s1 <= 1'b0;
		end else begin
			pend_vld_s1 <= mul_issue;
			if (in_xfer) begin
				ax_q   <= '0;
				step_q <= '0;
				row_q  <= '0;
			end else begin
				if (trig_wr)
					ax_q <= ax_q + 2'd1;
				if (mul_issue)
					step_q <= step_q + 4'd1;
				if (out_load)
					row_q <= row_q + 2'd1;
			end
		end
	end

	// ---------------- pose update ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				pos_q[i] <= '0;
				ang_q[i] <= '0;
			end
		end else if (in_xfer) begin
			for (int i = 0; i < 3; i++) begin
				case (cmd)
					epm_pkg::CMD_SET_POS: pos_q[i] <= in_pos[i];
					epm_pkg::CMD_ADD_POS: pos_q[i] <= epm_pkg::sat_add(pos_q[i], in_pos[i]);
					epm_pkg::CMD_SET_ANG: ang_q[i] <= in_ang[i];
					epm_pkg::CMD_ADD_ANG: ang_q[i] <= ang_q[i] + in_ang[i];  // wraps
					default:              pos_q[i] <= pos_q[i];
				endcase
			end
		end
	end

	// ---------------- sine / cosine ----------------
	epm_cordic #(
		.ANGLE_BITS      (ANGLE_BITS),
		.SINE_ITERATIONS (SINE_ITERATIONS)
	) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (trig_start),
		.angle  (ang_q[ax_q]),
		.res    (trig)
	);

	always_ff @(posedge clk) begin
		if (trig_wr) begin
			sin_q[ax_q] <= trig.sin_v;
			cos_q[ax_q] <= trig.cos_v;
		end
	end

	// ---------------- products ----------------
	function automatic logic signed [31:0] pick(input epm_pkg::src_t s,
	                                            input logic signed [31:0] cpsy,
	                                            input logic signed [31:0] spsy,
	                                            input logic signed [31:0] sn [3],
	                                            input logic signed [31:0] cs [3]);
		logic signed [31:0] v;
		v = '0;
		case (s)
			epm_pkg::SRC_SY:   v = sn[epm_pkg::AX_YAW];
			epm_pkg::SRC_CY:   v = cs[epm_pkg::AX_YAW];
			epm_pkg::SRC_SP:   v = sn[epm_pkg::AX_PITCH];
			epm_pkg::SRC_CP:   v = cs[epm_pkg::AX_PITCH];
			epm_pkg::SRC_SR:   v = sn[epm_pkg::AX_ROLL];
			epm_pkg::SRC_CR:   v = cs[epm_pkg::AX_ROLL];
			epm_pkg::SRC_CPSY: v = cpsy;
			epm_pkg::SRC_SPSY: v = spsy;
			default:           v = '0;
		endcase
		return v;
	endfunction

	assign cur_op = epm_pkg::mul_step(step_q);
	assign mul_a  = pick(cur_op.src_a, acc_q[epm_pkg::DST_CPSY][31:0],
	                     acc_q[epm_pkg::DST_SPSY][31:0], sin_q, cos_q);
	assign mul_b  = pick(cur_op.src_b, acc_q[epm_pkg::DST_CPSY][31:0],
	                     acc_q[epm_pkg::DST_SPSY][31:0], sin_q, cos_q);

	epm_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.q   (mul_q)
	);

	// write-back in the cycle after issue; second term of a sum lands on the first
	assign acc_old = acc_q[pend_op_s1.dst];

	always_comb begin
		case (pend_op_s1.mode)
			epm_pkg::ACC_ADD: wb_val = acc_old + {mul_q[31], mul_q};
			epm_pkg::ACC_SUB: wb_val = acc_old - {mul_q[31], mul_q};
			default:          wb_val = {mul_q[31], mul_q};
		endcase
	end

	always_ff @(posedge clk) begin
		if (mul_issue)
			pend_op_s1 <= cur_op;
		if (pend_vld_s1)
			acc_q[pend_op_s1.dst] <= wb_val;
	end

	// ---------------- output register ----------------
	logic [31:0]        row_a, row_b, row_c, row_d;
	logic signed [32:0] neg_sy;

	assign neg_sy = -{sin_q[epm_pkg::AX_YAW][31], sin_q[epm_pkg::AX_YAW]};

	always_comb begin
		case (row_q)
			2'd0: begin
				row_a = epm_pkg::to_q16(acc_q[epm_pkg::DST_M00]);
				row_b = epm_pkg::to_q16(acc_q[epm_pkg::DST_M01]);
				row_c = epm_pkg::to_q16(neg_sy);
				row_d = epm_pkg::FIXED_ZERO;
			end
			2'd1: begin
				row_a = epm_pkg::to_q16(acc_q[epm_pkg::DST_M10]);
				row_b = epm_pkg::to_q16(acc_q[epm_pkg::DST_M11]);
				row_c = epm_pkg::to_q16(acc_q[epm_pkg::DST_M12]);
				row_d = epm_pkg::FIXED_ZERO;
			end
			2'd2: begin
				row_a = epm_pkg::to_q16(acc_q[epm_pkg::DST_M20]);
				row_b = epm_pkg::to_q16(acc_q[epm_pkg::DST_M21]);
				row_c = epm_pkg::to_q16(acc_q[epm_pkg::DST_M22]);
				row_d = epm_pkg::FIXED_ZERO;
			end
			default: begin
				// translation row
				row_a = pos_q[0];
				row_b = pos_q[1];
				row_c = pos_q[2];
				row_d = epm_pkg::FIXED_ONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_vld_q <= 1'b0;
		else if (out_load)
			out_vld_q <= 1'b1;
		else if (m_axis_tready)
			out_vld_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= {row_d, row_c, row_b, row_a};
			out_row_q  <= row_q;
			out_last_q <= (row_q == epm_pkg::ROW_LAST);
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_row_q;
	assign m_axis_tlast  = out_last_q;

endmodule

[hdl/epm_cordic.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epm_cordic: iterative sine/cosine unit
// One shift-add rotation per cycle in Q2.30; angles near a half turn are
// folded and the result negated.
// ----------------------------------------------------------------------------
module epm_cordic #(
	parameter int ANGLE_BITS      = epm_pkg::ANGLE_BITS_DEF,
	parameter int SINE_ITERATIONS = epm_pkg::SINE_ITERATIONS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [15:0]         angle,
	output epm_pkg::trig_res_t  res
);

	localparam int ITER = (SINE_ITERATIONS < epm_pkg::ATAN_DEPTH) ?
	                      SINE_ITERATIONS : epm_pkg::ATAN_DEPTH;
	localparam logic [4:0]  LAST_IT    = 5'(ITER - 1);
	localparam logic [31:0] PHASE_MASK = ~((32'd1 << (32 - ANGLE_BITS)) - 32'd1);

	logic               busy_q, done_q, flip_q;
	logic [4:0]         it_q;
	logic signed [31:0] x_q, y_q, z_q;

	logic [31:0]        phase;
	logic               flip;
	logic signed [31:0] dx, dy, atan_v;

	assign phase  = {angle, 16'h0} & PHASE_MASK;
	assign flip   = phase[31] ^ phase[30];
	assign dx     = y_q >>> it_q;
	assign dy     = x_q >>> it_q;
	assign atan_v = signed'(epm_pkg::atan_turn(it_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			it_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				it_q   <= '0;
			end else if (busy_q) begin
				it_q <= it_q + 5'd1;
				if (it_q == LAST_IT) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= epm_pkg::CORDIC_START;
			y_q    <= '0;
			z_q    <= signed'({phase[31] ^ flip, phase[30:0]});
			flip_q <= flip;
		end else if (busy_q) begin
			if (!z_q[31]) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - atan_v;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + atan_v;
			end
		end
	end

	assign res.done  = done_q;
	assign res.sin_v = flip_q ? -y_q : y_q;
	assign res.cos_v = flip_q ? -x_q : x_q;

endmodule

[hdl/epm_mul.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epm_mul: shared Q2.30 multiplier
// Registered 32x32 product, then round-half-up back to Q2.30.
// ----------------------------------------------------------------------------
module epm_mul (
	input  logic               clk,
	input  logic signed [31:0] a,
	input  logic signed [31:0] b,
	output logic signed [31:0] q
);

	logic signed [63:0] prod_s1;
	logic signed [63:0] rnd;

	always_ff @(posedge clk) begin
		prod_s1 <= a * b;
	end

	// floor((p + 2^29) / 2^30); values stay within Q2.30 range
	assign rnd = prod_s1 + 64'sd536870912;
	assign q   = rnd[61:30];

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for euler_pose_to_matrix
// Streams pose commands into the slave side and predicts the four matrix
// rows of each one with an independent CORDIC and Q2.30 product model. The
// rows on the master side are compared field by field against that model.
// Both sides idle at random, with one stretch of steady flow.
// ----------------------------------------------------------------------------
module tb;

	localparam int  ANGLE_BITS      = epm_pkg::ANGLE_BITS_DEF;
	localparam int  SINE_ITERATIONS = epm_pkg::SINE_ITERATIONS_DEF;
	localparam int  RANDOM_ITEMS    = 330;
	localparam int  TAIL_CYCLES     = 100;   // idle tail after the final drain
	localparam real HALF_PERIOD     = 6.0;

	localparam longint      CORDIC_X0   = 64'sh26DD3B6A;  // 1/gain in Q2.30
	localparam logic [31:0] Q16_ONE     = 32'h0001_0000;
	localparam logic [31:0] PHASE_CLEAR = 32'((64'd1 << (32 - ANGLE_BITS)) - 64'd1);

	// arctan(2^-i) in 2^-32 turns, entry 0 in the top word
	localparam logic [24*32-1:0] ATAN_TURNS = {
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
	};

	typedef struct packed {
		logic [1:0]  row;
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
		logic [31:0] d;
		logic        last;
	} pose_row_t;

	logic         clk           = 1'b0;
	logic         arst_n        = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [143:0] s_axis_tdata  = '0;   // pos_x, pos_y, pos_z, yaw, pitch, roll
	logic [1:0]   s_axis_tuser  = '0;   // command
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [127:0] m_axis_tdata;         // entry_a, entry_b, entry_c, entry_d
	logic [1:0]   m_axis_tuser;         // row_index
	logic         m_axis_tlast;         // last_row

	// predicted pose
	logic signed [31:0] pose_pos [3];
	logic [15:0]        pose_ang [3];

	pose_row_t rows_due [$];
	pose_row_t row_want;

	int  mismatches  = 0;
	int  rows_seen   = 0;
	int  cmds_sent   = 0;
	int  sat_hits    = 0;
	int  cmd_hist [4];
	bit  steady_flow = 1'b0;

	euler_pose_to_matrix #(
		.ANGLE_BITS      (ANGLE_BITS),
		.SINE_ITERATIONS (SINE_ITERATIONS)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// ------------------------------------------------------------------------
	// model
	// ------------------------------------------------------------------------

	// Q2.30 x Q2.30, round half up
	function automatic longint q30_mul(input longint a, input longint b);
		return (a * b + 64'sd536870912) >>> 30;
	endfunction

	function automatic logic [31:0] q30_to_q16(input longint v);
		longint t;
		t = (v + 64'sd8192) >>> 14;
		return t[31:0];
	endfunction

	task automatic cordic_sin_cos(input logic [15:0] ang, output longint s, output longint c);
		logic [31:0] ph;
		logic        flip;
		longint      x, y, z, dx, dy;
		ph   = {ang, 16'h0000} & ~PHASE_CLEAR;
		// back half turn: rotate by 180 degrees, negate afterwards
		flip = (ph >= 32'h4000_0000) && (ph < 32'hC000_0000);
		if (flip)
			ph = ph - 32'h8000_0000;
		z = longint'($signed(ph));
		x = CORDIC_X0;
		y = 0;
		for (int i = 0; i < SINE_ITERATIONS && i < 24; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x = x - dx;
				y = y + dy;
				z = z - longint'(ATAN_TURNS[(23 - i) * 32 +: 32]);
			end else begin
				x = x + dx;
				y = y - dy;
				z = z + longint'(ATAN_TURNS[(23 - i) * 32 +: 32]);
			end
		end
		if (flip) begin
			x = -x;
			y = -y;
		end
		s = y;
		c = x;
	endtask

	task automatic predict_pose_rows(input epm_pkg::cmd_t cmd, input logic [31:0] px,
	                                 input logic [31:0] py,
	                                 input logic [31:0] pz, input logic [15:0] ay,
	                                 input logic [15:0] ap, input logic [15:0] ar);
		logic signed [31:0] off [3];
		logic [15:0]        dang [3];
		longint             sum;
		longint             sy, cy, sp, cp, sr, cr, cpsy, spsy;
		longint             m [3][3];
		pose_row_t          r;
		off[0]  = px;
		off[1]  = py;
		off[2]  = pz;
		dang[0] = ay;
		dang[1] = ap;
		dang[2] = ar;
		for (int i = 0; i < 3; i++) begin
			case (cmd)
				epm_pkg::CMD_SET_POS: pose_pos[i] = off[i];
				epm_pkg::CMD_ADD_POS: begin
					sum = longint'(pose_pos[i]) + longint'(off[i]);
					if (sum > 64'sd2147483647) begin
						pose_pos[i] = 32'sh7FFF_FFFF;
						sat_hits++;
					end else if (sum < -64'sd2147483648) begin
						pose_pos[i] = 32'sh8000_0000;
						sat_hits++;
					end else begin
						pose_pos[i] = sum[31:0];
					end
				end
				epm_pkg::CMD_SET_ANG: pose_ang[i] = dang[i];
				default:              pose_ang[i] = pose_ang[i] + dang[i];   // wraps at one turn
			endcase
		end

		cordic_sin_cos(pose_ang[epm_pkg::AX_YAW],   sy, cy);
		cordic_sin_cos(pose_ang[epm_pkg::AX_PITCH], sp, cp);
		cordic_sin_cos(pose_ang[epm_pkg::AX_ROLL],  sr, cr);
		cpsy = q30_mul(cp, sy);
		spsy = q30_mul(sp, sy);

		m[0][0] = q30_mul(cp, cy);
		m[0][1] = q30_mul(sp, cy);
		m[0][2] = -sy;
		m[1][0] = q30_mul(cpsy, sr) - q30_mul(sp, cr);
		m[1][1] = q30_mul(spsy, sr) + q30_mul(cp, cr);
		m[1][2] = q30_mul(cy, sr);
		m[2][0] = q30_mul(cpsy, cr) + q30_mul(sp, sr);
		m[2][1] = q30_mul(spsy, cr) - q30_mul(cp, sr);
		m[2][2] = q30_mul(cy, cr);

		for (int k = 0; k < 3; k++) begin
			r.row  = 2'(k);
			r.a    = q30_to_q16(m[k][0]);
			r.b    = q30_to_q16(m[k][1]);
			r.c    = q30_to_q16(m[k][2]);
			r.d    = '0;
			r.last = 1'b0;
			rows_due.push_back(r);
		end
		// translation row
		r.row  = epm_pkg::ROW_LAST;
		r.a    = pose_pos[0];
		r.b    = pose_pos[1];
		r.c    = pose_pos[2];
		r.d    = Q16_ONE;
		r.last = 1'b1;
		rows_due.push_back(r);
	endtask

	// ------------------------------------------------------------------------
	// slave side: one command per call
	// ------------------------------------------------------------------------
	task automatic send_pose_cmd(input epm_pkg::cmd_t cmd, input logic [31:0] px,
	                             input logic [31:0] py,
	                             input logic [31:0] pz, input logic [15:0] ay,
	                             input logic [15:0] ap, input logic [15:0] ar);
		if (!steady_flow) begin
			while ($urandom_range(99) < 25) begin
				s_axis_tvalid <= 1'b0;
				@(posedge clk);
			end
			// now and then a long gap so that the next command lands late
			if ($urandom_range(99) < 8) begin
				s_axis_tvalid <= 1'b0;
				repeat ($urandom_range(1, 90)) @(posedge clk);
			end
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {ar, ap, ay, pz, py, px};
		s_axis_tuser  <= cmd;
		do @(posedge clk); while (!s_axis_tready);
		predict_pose_rows(cmd, px, py, pz, ay, ap, ar);
		cmds_sent++;
		cmd_hist[cmd]++;
	endtask

	// drop tvalid and hold off until every predicted row has been seen
	task automatic drain_rows;
		s_axis_tvalid <= 1'b0;
		while (rows_due.size() != 0) @(posedge clk);
	endtask

	// ------------------------------------------------------------------------
	// master side: random back-pressure and row check
	// ------------------------------------------------------------------------
	always @(posedge clk)
		m_axis_tready <= steady_flow || ($urandom_range(99) >= 25);

	task automatic report_mismatch(input string field, input logic [31:0] got,
	                               input logic [31:0] want);
		$display("%0t ns: row %0d %s: got %h, want %h", $time, m_axis_tuser, field, got, want);
		mismatches++;
	endtask

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			rows_seen++;
			if (rows_due.size() == 0) begin
				report_mismatch("unexpected transfer", m_axis_tdata[31:0], '0);
			end else begin
				row_want = rows_due.pop_front();
				if (m_axis_tuser != row_want.row)
					report_mismatch("row_index", 32'(m_axis_tuser), 32'(row_want.row));
				if (m_axis_tdata[31:0] != row_want.a)
					report_mismatch("entry_a", m_axis_tdata[31:0], row_want.a);
				if (m_axis_tdata[63:32] != row_want.b)
					report_mismatch("entry_b", m_axis_tdata[63:32], row_want.b);
				if (m_axis_tdata[95:64] != row_want.c)
					report_mismatch("entry_c", m_axis_tdata[95:64], row_want.c);
				if (m_axis_tdata[127:96] != row_want.d)
					report_mismatch("entry_d", m_axis_tdata[127:96], row_want.d);
				if (m_axis_tlast != row_want.last)
					report_mismatch("last_row", 32'(m_axis_tlast), 32'(row_want.last));
			end
		end
	end

	// ------------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------------
	function automatic logic [31:0] pick_q16;
		case ($urandom_range(3))
			0:       return 32'h7FFF_FFFF - $urandom_range(0, 65535);   // near top
			1:       return 32'h8000_0000 + $urandom_range(0, 65535);   // near bottom
			2:       return 32'($urandom_range(0, 262143)) - 32'd131072; // small offset
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [15:0] pick_angle;
		case ($urandom_range(3))
			// around the quarter turns, where the half-turn fold switches
			0:       return 16'({$urandom_range(3), 14'h0}) + 16'($urandom_range(0, 4)) - 16'd2;
			1:       return 16'($urandom_range(0, 255)) - 16'd128;
			default: return 16'($urandom);
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------

	// zero adds right after reset: identity rotation at the origin
	task automatic test_reset_pose;
		send_pose_cmd(epm_pkg::CMD_ADD_POS, '0, '0, '0,
		              16'($urandom), 16'($urandom), 16'($urandom));
		send_pose_cmd(epm_pkg::CMD_ADD_ANG, $urandom, $urandom, $urandom, '0, '0, '0);
	endtask

	// quarter-turn boundaries, extremes and wrap of angle adds
	task automatic test_angle_extremes;
		send_pose_cmd(epm_pkg::CMD_SET_ANG, $urandom, $urandom, $urandom,
		              16'h4000, 16'h8000, 16'hC000);
		send_pose_cmd(epm_pkg::CMD_SET_ANG, $urandom, $urandom, $urandom,
		              16'h3FFF, 16'h7FFF, 16'hBFFF);
		send_pose_cmd(epm_pkg::CMD_SET_ANG, $urandom, $urandom, $urandom,
		              16'hFFFF, 16'h0001, 16'h8001);
		send_pose_cmd(epm_pkg::CMD_SET_ANG, $urandom, $urandom, $urandom,
		              16'h7FFF, 16'hFFFF, 16'h0000);
		send_pose_cmd(epm_pkg::CMD_ADD_ANG, $urandom, $urandom, $urandom,
		              16'h0001, 16'h0001, 16'h8000);
		send_pose_cmd(epm_pkg::CMD_ADD_ANG, $urandom, $urandom, $urandom,
		              16'h8000, 16'h7FFF, 16'hFFFF);
		send_pose_cmd(epm_pkg::CMD_ADD_ANG, $urandom, $urandom, $urandom,
		              16'hFFFF, 16'h8000, 16'h4001);
		send_pose_cmd(epm_pkg::CMD_SET_ANG, $urandom, $urandom, $urandom,
		              16'hC000, 16'h4000, 16'h8000);
	endtask

	// full-range positions and saturating adds in both directions
	task automatic test_position_saturation;
		send_pose_cmd(epm_pkg::CMD_SET_POS, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000,
		              16'($urandom), 16'($urandom), 16'($urandom));
		send_pose_cmd(epm_pkg::CMD_ADD_POS, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
		              16'($urandom), 16'($urandom), 16'($urandom));
		send_pose_cmd(epm_pkg::CMD_ADD_POS, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001,
		              16'($urandom), 16'($urandom), 16'($urandom));
		send_pose_cmd(epm_pkg::CMD_SET_POS, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000,
		              16'($urandom), 16'($urandom), 16'($urandom));
		send_pose_cmd(epm_pkg::CMD_ADD_POS, 32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF,
		              16'($urandom), 16'($urandom), 16'($urandom));
		send_pose_cmd(epm_pkg::CMD_ADD_POS, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
		              16'($urandom), 16'($urandom), 16'($urandom));
		send_pose_cmd(epm_pkg::CMD_SET_POS, 32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA,
		              16'($urandom), 16'($urandom), 16'($urandom));
	endtask

	// random commands; one stretch with no idling, one full drain midway
	task automatic test_random_stream;
		epm_pkg::cmd_t cmd;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			steady_flow = (n >= 120) && (n < 180);
			if (n == 240)
				drain_rows();
			cmd = epm_pkg::cmd_t'($urandom_range(3));
			if (cmd == epm_pkg::CMD_SET_POS || cmd == epm_pkg::CMD_ADD_POS)
				send_pose_cmd(cmd, pick_q16(), pick_q16(), pick_q16(),
				              16'($urandom), 16'($urandom), 16'($urandom));
			else
				send_pose_cmd(cmd, $urandom, $urandom, $urandom,
				              pick_angle(), pick_angle(), pick_angle());
		end
		steady_flow = 1'b0;
	endtask

	initial begin
		for (int i = 0; i < 3; i++) begin
			pose_pos[i] = '0;
			pose_ang[i] = '0;
		end
		for (int i = 0; i < 4; i++)
			cmd_hist[i] = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_pose();
		test_angle_extremes();
		test_position_saturation();
		drain_rows();
		test_random_stream();

		drain_rows();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d commands: set pos %0d, add pos %0d, set angles %0d, add angles %0d",
		         cmds_sent, cmd_hist[epm_pkg::CMD_SET_POS], cmd_hist[epm_pkg::CMD_ADD_POS],
		         cmd_hist[epm_pkg::CMD_SET_ANG], cmd_hist[epm_pkg::CMD_ADD_ANG]);
		$display("checked %0d rows, %0d saturated coordinates, %0d errors",
		         rows_seen, sat_hits, mismatches);
		if (mismatches == 0 && rows_due.size() == 0)
			$display("euler_pose_to_matrix: match");
		else
			$display("euler_pose_to_matrix: mismatch");
		$finish;
	end

	// watchdog, several times the slowest legal run
	initial begin
		#(5_000_000);
		$display("timeout with %0d rows outstanding", rows_due.size());
		$display("euler_pose_to_matrix: mismatch");
		$finish;
	end

endmodule
